@@ rtl/core/mt19937_byte_keystream_xor_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the keystream block
// Shared shorthand for clocked properties that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MT19937_BYTE_KEYSTREAM_XOR_MACROS_SVH
`define MT19937_BYTE_KEYSTREAM_XOR_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define MTKS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define MTKS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/mtks_pkg.sv @@
// ----------------------------------------------------------------------------
// mtks_pkg
// Constants and operation codes shared by the keystream datapath and sequencer.
// ----------------------------------------------------------------------------
package mtks_pkg;

  localparam int unsigned N       = 624;
  localparam int unsigned M       = 397;
  localparam int unsigned SPLIT   = 227;
  localparam int unsigned ADDR_W  = 10;
  localparam int unsigned WORD_W  = 32;

  localparam logic [31:0] MATRIX   = 32'h9908b0df;
  localparam logic [31:0] MID_MASK = 32'h7ffffffe;
  localparam logic [31:0] INIT_MUL = 32'h6c078965;
  localparam logic [31:0] TEMPER_B = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C = 32'hefc60000;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_ADD,
    OP_TWIST,
    OP_TEMPER
  } op_t;

endpackage

@@ rtl/core/mt19937_byte_keystream_xor.sv @@
// ----------------------------------------------------------------------------
// mt19937_byte_keystream_xor
// Byte stream cipher that XORs each byte with bits 8..1 of a tempered
// Mersenne Twister word.
// ----------------------------------------------------------------------------
// Usage: write the seed through cfg_we and cfg_data while the block is idle.
// Requests enter on in_valid with data_byte and first; the block raises
// in_stall from the cycle after acceptance until it returns to idle.
// A request with first set reseeds the 624-word state from the seed before
// its byte is handled; the seeding recurrence runs through the shared unit
// with a multiply state and then an add state for each word.
// Each byte twists its state word in place with three reads of the single
// RAM read port, then tempers it; the read, twist and temper states lie
// between acceptance and the registered result on out_valid and out_byte.
// No new request is taken before idle; the read port and unit set this pace.
// If the receiver holds out_stall, the finished result stays in the output
// register and the next request may still be accepted, but that request
// waits before delivery until the output register is free.
// Reset clears the sequencer, the word position, the output valid flag and
// the seed register; the state words stay undefined until a first request.
// ----------------------------------------------------------------------------
`include "mt19937_byte_keystream_xor_macros.svh"

module mt19937_byte_keystream_xor (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        first,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_ADD,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_TW,
    ST_TEMP,
    ST_DONE
  } state_t;

  localparam logic [mtks_pkg::ADDR_W-1:0] LAST  = mtks_pkg::ADDR_W'(mtks_pkg::N - 1);
  localparam logic [mtks_pkg::ADDR_W-1:0] OFF_M = mtks_pkg::ADDR_W'(mtks_pkg::M);
  localparam logic [mtks_pkg::ADDR_W-1:0] OFF_S = mtks_pkg::ADDR_W'(mtks_pkg::SPLIT);

  state_t                         state;
  logic [31:0]                    seed;
  logic [31:0]                    acc;
  logic [31:0]                    nxt;
  logic [7:0]                     data;
  logic [mtks_pkg::ADDR_W-1:0]    pos;
  logic [mtks_pkg::ADDR_W-1:0]    idx;
  logic [mtks_pkg::ADDR_W-1:0]    pos_next;
  logic [mtks_pkg::ADDR_W-1:0]    far_addr;

  logic                           mem_we;
  logic [mtks_pkg::ADDR_W-1:0]    mem_waddr;
  logic [31:0]                    mem_wdata;
  logic [mtks_pkg::ADDR_W-1:0]    mem_raddr;
  logic [31:0]                    mem_rdata;

  mtks_pkg::op_t                  op;
  logic [31:0]                    unit_y;
  logic                           accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign pos_next = (pos == LAST) ? '0 : pos + 1'b1;
  assign far_addr = (pos < OFF_S) ? pos + OFF_M : pos - OFF_S;

  mtks_ram #(
    .DEPTH (mtks_pkg::N),
    .WIDTH (mtks_pkg::WORD_W),
    .ADDR_W(mtks_pkg::ADDR_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  mtks_unit u_unit (
    .op (op),
    .a  (acc),
    .b  (nxt),
    .c  (mem_rdata),
    .idx(idx),
    .y  (unit_y)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos;
    mem_wdata = unit_y;
    mem_raddr = pos;
    op        = mtks_pkg::OP_TEMPER;
    case (state)
      ST_IDLE: begin
        mem_we    = accept && first;
        mem_waddr = '0;
        mem_wdata = seed;
      end
      ST_SEED_MUL: begin
        op = mtks_pkg::OP_MUL;
      end
      ST_SEED_ADD: begin
        op        = mtks_pkg::OP_ADD;
        mem_we    = 1'b1;
        mem_waddr = idx;
      end
      ST_RD1: begin
        mem_raddr = pos_next;
      end
      ST_RD2: begin
        mem_raddr = far_addr;
      end
      ST_TW: begin
        op     = mtks_pkg::OP_TWIST;
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      pos       <= '0;
      seed      <= '0;
    end else begin
      if (cfg_we) begin
        seed <= cfg_data;
      end
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            data <= data_byte;
            if (first) begin
              acc   <= seed;
              idx   <= mtks_pkg::ADDR_W'(1);
              state <= ST_SEED_MUL;
            end else begin
              state <= ST_RD0;
            end
          end
        end
        ST_SEED_MUL: begin
          acc   <= unit_y;
          state <= ST_SEED_ADD;
        end
        ST_SEED_ADD: begin
          acc <= unit_y;
          if (idx == LAST) begin
            pos   <= '0;
            state <= ST_RD0;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_SEED_MUL;
          end
        end
        ST_RD0: begin
          state <= ST_RD1;
        end
        ST_RD1: begin
          acc   <= mem_rdata;
          state <= ST_RD2;
        end
        ST_RD2: begin
          nxt   <= mem_rdata;
          state <= ST_TW;
        end
        ST_TW: begin
          acc   <= unit_y;
          state <= ST_TEMP;
        end
        ST_TEMP: begin
          acc   <= unit_y;
          pos   <= pos_next;
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_byte  <= data ^ acc[8:1];
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `MTKS_ASSERT_SAME(a_pos_range, 1'b1, pos <= LAST, "word position out of range")
  `MTKS_ASSERT_NEXT(a_busy_after_accept, accept, in_stall, "not busy after a request")
  `MTKS_ASSERT_NEXT(a_seed_start, accept && first, state == ST_SEED_MUL && idx == 1, "no seeding")
  `MTKS_ASSERT_NEXT(a_twist_then_temper, state == ST_TW, state == ST_TEMP, "twist not followed by tempering")

endmodule

@@ rtl/core/mtks_ram.sv @@
// ----------------------------------------------------------------------------
// mtks_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module mtks_ram #(
  parameter int unsigned DEPTH = 624,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/mtks_unit.sv @@
// ----------------------------------------------------------------------------
// mtks_unit
// Shared arithmetic unit: seeding multiply and add, twist, and tempering.
// ----------------------------------------------------------------------------
module mtks_unit (
  input  mtks_pkg::op_t                     op,
  input  logic [mtks_pkg::WORD_W-1:0]       a,
  input  logic [mtks_pkg::WORD_W-1:0]       b,
  input  logic [mtks_pkg::WORD_W-1:0]       c,
  input  logic [mtks_pkg::ADDR_W-1:0]       idx,
  output logic [mtks_pkg::WORD_W-1:0]       y
);

  logic [31:0] mix;
  logic [31:0] tw;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] t3;

  always_comb begin
    mix = a ^ (a >> 30);
    tw  = ((((a ^ b) & mtks_pkg::MID_MASK) ^ a) >> 1)
          ^ (b[0] ? mtks_pkg::MATRIX : 32'h0) ^ c;
    t1  = a ^ (a >> 11);
    t2  = t1 ^ ((t1 << 7) & mtks_pkg::TEMPER_B);
    t3  = t2 ^ ((t2 << 15) & mtks_pkg::TEMPER_C);
    case (op)
      mtks_pkg::OP_MUL: begin
        y = mtks_pkg::INIT_MUL * mix;
      end
      mtks_pkg::OP_ADD: begin
        y = a + {22'h0, idx};
      end
      mtks_pkg::OP_TWIST: begin
        y = tw;
      end
      default: begin
        y = t3 ^ (t3 >> 18);
      end
    endcase
  end

endmodule
